// File: src/mvbbox_pkg.sv
// Package for the vertex store, bounding box and face normal block.
// Holds sizes, field widths, command and status codes. No dependencies.
`default_nettype none

package mvbbox_pkg;

	localparam int VERTEX_DEPTH = 1024;
	localparam int FACE_LIMIT   = 4096;

	localparam int COORD_W  = 16;
	localparam int CORNER_W = 10;
	localparam int INDEX_W  = 12;
	localparam int NORM_W   = 34;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int VERT_W   = 3 * COORD_W;

	localparam int VX_AW  = $clog2(VERTEX_DEPTH);
	localparam int VCNT_W = $clog2(VERTEX_DEPTH + 1);
	localparam int FCNT_W = $clog2(FACE_LIMIT + 1);

	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_FACE   = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_UNWRITTEN = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: src/mesh_vertex_bbox_face_normal.sv
// Top level: vertex store with running bounding box and triangle face normals.
// Depends on mvbbox_pkg for sizes and codes; the vertex memory lives inside.
//
// Usage
// The input channel (in_valid / in_stall) carries one request per handshake:
// command 0 adds the vertex coord_x/y/z, command 1 adds a face whose corners
// are corner_a/b/c. Each request gives exactly one result on the output
// channel (out_valid / out_stall), held in an output register.
// A vertex request, and a face request refused for a full face count or an
// unwritten corner, is written into the output register as it is accepted.
// A good face request first reads the three corners, in ST_READ,
// through the single read port of the vertex memory, then one shared 17 by 17
// multiplier forms the six cross product terms, one per cycle, with a final
// subtract before the result is registered. The block takes a new request
// only once the previous one has gone to the output register, and not while
// that register holds a result the receiver is stalling, so a stalled output
// holds the block in place. Reset empties the vertex and face counts and the
// bounding box; no clearing pass is needed because corners at or beyond the
// vertex count are refused before any read of the memory.
`default_nettype none

module mesh_vertex_bbox_face_normal
	import mvbbox_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,

	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        command,
	input  wire  signed [COORD_W-1:0]  coord_x,
	input  wire  signed [COORD_W-1:0]  coord_y,
	input  wire  signed [COORD_W-1:0]  coord_z,
	input  wire         [CORNER_W-1:0] corner_a,
	input  wire         [CORNER_W-1:0] corner_b,
	input  wire         [CORNER_W-1:0] corner_c,

	output logic                       out_valid,
	input  wire                        out_stall,
	output logic        [1:0]          status,
	output logic        [INDEX_W-1:0]  entry_index,
	output logic signed [COORD_W-1:0]  lo_x,
	output logic signed [COORD_W-1:0]  lo_y,
	output logic signed [COORD_W-1:0]  lo_z,
	output logic        [COORD_W-1:0]  extent_x,
	output logic        [COORD_W-1:0]  extent_y,
	output logic        [COORD_W-1:0]  extent_z,
	output logic signed [NORM_W-1:0]   normal_x,
	output logic signed [NORM_W-1:0]   normal_y,
	output logic signed [NORM_W-1:0]   normal_z
);

	// Sequencer states: read the corners, run the multiplier, hand over.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Vertex memory: one write port used on vertex requests, one registered
	// read port used while a face is being read. Word layout is {z, y, x}.
	logic [VERT_W-1:0] vmem [VERTEX_DEPTH];
	logic [VERT_W-1:0] rdata_q;
	logic [VX_AW-1:0]  raddr;
	logic              mem_we;
	logic [VERT_W-1:0] mem_wdata;

	logic [VCNT_W-1:0] vcount_q;
	logic [FCNT_W-1:0] fcount_q;
	logic              box_valid_q;
	logic signed [COORD_W-1:0] box_min_q [3];
	logic signed [COORD_W-1:0] box_max_q [3];
	logic signed [COORD_W-1:0] min_nxt [3];
	logic signed [COORD_W-1:0] max_nxt [3];
	logic signed [COORD_W-1:0] coord_in [3];

	// Face datapath registers.
	logic [CORNER_W-1:0]       ca_q, cb_q, cc_q;
	logic [1:0]                rd_cnt_q;
	logic [VERT_W-1:0]         va_q, vb_q;
	logic signed [DIFF_W-1:0]  d1_q [3];
	logic signed [DIFF_W-1:0]  d2_q [3];
	logic [2:0]                step_q;
	logic signed [DIFF_W-1:0]  mul_a, mul_b;
	logic signed [NORM_W-1:0]  prod_q;
	logic signed [NORM_W-1:0]  acc_q;
	logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;

	// Output register.
	logic                      out_valid_q;
	status_t                   status_q;
	logic [INDEX_W-1:0]        index_q;
	logic signed [COORD_W-1:0] lo_q [3];
	logic [COORD_W-1:0]        ext_q [3];
	logic signed [NORM_W-1:0]  onx_q, ony_q, onz_q;

	logic accept;
	logic out_free;
	logic vert_full;
	logic face_full;
	logic corner_bad;

	function automatic logic signed [DIFF_W-1:0] axis_diff(
		input logic [VERT_W-1:0] p,
		input logic [VERT_W-1:0] q,
		input int unsigned       axis
	);
		logic signed [COORD_W-1:0] pa;
		logic signed [COORD_W-1:0] qa;
		pa = p[COORD_W*axis +: COORD_W];
		qa = q[COORD_W*axis +: COORD_W];
		return DIFF_W'(pa) - DIFF_W'(qa);
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	assign vert_full  = (vcount_q >= VCNT_W'(VERTEX_DEPTH));
	assign face_full  = (fcount_q >= FCNT_W'(FACE_LIMIT));
	assign corner_bad = ({1'b0, corner_a} >= (CORNER_W+1)'(vcount_q))
		|| ({1'b0, corner_b} >= (CORNER_W+1)'(vcount_q))
		|| ({1'b0, corner_c} >= (CORNER_W+1)'(vcount_q));

	assign coord_in[0] = coord_x;
	assign coord_in[1] = coord_y;
	assign coord_in[2] = coord_z;

	// Widened box for a vertex request; the first vertex sets both corners.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!box_valid_q) begin
				min_nxt[i] = coord_in[i];
				max_nxt[i] = coord_in[i];
			end else begin
				min_nxt[i] = (coord_in[i] < box_min_q[i]) ? coord_in[i] : box_min_q[i];
				max_nxt[i] = (coord_in[i] > box_max_q[i]) ? coord_in[i] : box_max_q[i];
			end
		end
	end

	assign mem_we    = accept && (command == CMD_VERTEX) && !vert_full;
	assign mem_wdata = {coord_z, coord_y, coord_x};

	always_comb begin
		unique case (rd_cnt_q)
			2'd0:    raddr = VX_AW'(ca_q);
			2'd1:    raddr = VX_AW'(cb_q);
			default: raddr = VX_AW'(cc_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vmem[VX_AW'(vcount_q)] <= mem_wdata;
		end
		rdata_q <= vmem[raddr];
	end

	// Operand selection for the shared multiplier, one cross term per step.
	always_comb begin
		unique case (step_q)
			3'd0: begin mul_a = d1_q[1]; mul_b = d2_q[2]; end
			3'd1: begin mul_a = d1_q[2]; mul_b = d2_q[1]; end
			3'd2: begin mul_a = d1_q[2]; mul_b = d2_q[0]; end
			3'd3: begin mul_a = d1_q[0]; mul_b = d2_q[2]; end
			3'd4: begin mul_a = d1_q[0]; mul_b = d2_q[1]; end
			3'd5: begin mul_a = d1_q[1]; mul_b = d2_q[0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= '0;
			fcount_q    <= '0;
			box_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
				d1_q[i]      <= '0;
				d2_q[i]      <= '0;
				lo_q[i]      <= '0;
				ext_q[i]     <= '0;
			end
			ca_q        <= '0;
			cb_q        <= '0;
			cc_q        <= '0;
			rd_cnt_q    <= '0;
			va_q        <= '0;
			vb_q        <= '0;
			step_q      <= '0;
			prod_q      <= '0;
			acc_q       <= '0;
			nx_q        <= '0;
			ny_q        <= '0;
			nz_q        <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STATUS_OK;
			index_q     <= '0;
			onx_q       <= '0;
			ony_q       <= '0;
			onz_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid_q <= 1'b1;
						onx_q       <= '0;
						ony_q       <= '0;
						onz_q       <= '0;
						index_q     <= '0;
						if (command == CMD_VERTEX) begin
							if (vert_full) begin
								status_q <= STATUS_FULL;
								for (int i = 0; i < 3; i++) begin
									lo_q[i]  <= box_min_q[i];
									ext_q[i] <= COORD_W'(box_max_q[i] - box_min_q[i]);
								end
							end else begin
								status_q    <= STATUS_OK;
								index_q     <= INDEX_W'(vcount_q);
								vcount_q    <= vcount_q + 1'b1;
								box_valid_q <= 1'b1;
								for (int i = 0; i < 3; i++) begin
									box_min_q[i] <= min_nxt[i];
									box_max_q[i] <= max_nxt[i];
									lo_q[i]      <= min_nxt[i];
									ext_q[i]     <= COORD_W'(max_nxt[i] - min_nxt[i]);
								end
							end
						end else begin
							for (int i = 0; i < 3; i++) begin
								lo_q[i]  <= '0;
								ext_q[i] <= '0;
							end
							if (face_full) begin
								status_q <= STATUS_FULL;
							end else if (corner_bad) begin
								status_q <= STATUS_UNWRITTEN;
							end else begin
								// Good face: the result comes later from ST_DONE.
								out_valid_q <= 1'b0;
								ca_q        <= corner_a;
								cb_q        <= corner_b;
								cc_q        <= corner_c;
								rd_cnt_q    <= '0;
								state_q     <= ST_READ;
							end
						end
					end
				end

				ST_READ: begin
					rd_cnt_q <= rd_cnt_q + 1'b1;
					unique case (rd_cnt_q)
						2'd0: begin
						end
						2'd1: va_q <= rdata_q;
						2'd2: begin
							vb_q <= rdata_q;
							for (int i = 0; i < 3; i++) begin
								d1_q[i] <= axis_diff(va_q, rdata_q, i);
							end
						end
						default: begin
							for (int i = 0; i < 3; i++) begin
								d2_q[i] <= axis_diff(vb_q, rdata_q, i);
							end
							step_q  <= '0;
							state_q <= ST_MUL;
						end
					endcase
				end

				ST_MUL: begin
					prod_q <= mul_a * mul_b;
					step_q <= step_q + 1'b1;
					unique case (step_q)
						3'd1, 3'd3, 3'd5: acc_q <= prod_q;
						3'd2: nx_q <= acc_q - prod_q;
						3'd4: ny_q <= acc_q - prod_q;
						3'd6: begin
							nz_q    <= acc_q - prod_q;
							state_q <= ST_DONE;
						end
						default: begin
						end
					endcase
				end

				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= STATUS_OK;
						index_q     <= INDEX_W'(fcount_q);
						fcount_q    <= fcount_q + 1'b1;
						onx_q       <= nx_q;
						ony_q       <= ny_q;
						onz_q       <= nz_q;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_index = index_q;
	assign lo_x        = lo_q[0];
	assign lo_y        = lo_q[1];
	assign lo_z        = lo_q[2];
	assign extent_x    = ext_q[0];
	assign extent_y    = ext_q[1];
	assign extent_z    = ext_q[2];
	assign normal_x    = onx_q;
	assign normal_y    = ony_q;
	assign normal_z    = onz_q;

	// The counts never run past their limits.
	a_vcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= VCNT_W'(VERTEX_DEPTH))
		else $error("vertex count beyond store depth");

	a_fcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= FCNT_W'(FACE_LIMIT))
		else $error("face count beyond limit");

	// The vertex count moves only on an accepted vertex request.
	a_vcount_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(vcount_q != $past(vcount_q)) |->
			$past(in_valid && !in_stall && (command == CMD_VERTEX)))
		else $error("vertex count changed without a vertex request");

	// Once a vertex has been seen the box stays valid until reset.
	a_box_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid_q |=> box_valid_q)
		else $error("bounding box lost its valid flag");

	// The multiplier sequence never runs past its last step.
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q <= 3'd6))
		else $error("multiplier step out of range");

endmodule

`default_nettype wire

// File: dv/mvbbox_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the vertex store, bounding box and face normal block.
// Depends on mvbbox_pkg for sizes, field widths and command and status codes.

package mvbbox_tb_pkg;

	import mvbbox_pkg::*;

	typedef struct packed {
		status_t                    status;
		logic        [INDEX_W-1:0]  entry_index;
		logic signed [COORD_W-1:0]  lo_x;
		logic signed [COORD_W-1:0]  lo_y;
		logic signed [COORD_W-1:0]  lo_z;
		logic        [COORD_W-1:0]  extent_x;
		logic        [COORD_W-1:0]  extent_y;
		logic        [COORD_W-1:0]  extent_z;
		logic signed [NORM_W-1:0]   normal_x;
		logic signed [NORM_W-1:0]   normal_y;
		logic signed [NORM_W-1:0]   normal_z;
	} mesh_result_t;

	class mesh_scoreboard;

		logic signed [COORD_W-1:0] coords_held [VERTEX_DEPTH][3];
		int unsigned n_vertices = 0;
		int unsigned n_faces = 0;
		bit box_started = 1'b0;
		logic signed [COORD_W-1:0] box_lo [3] = '{0, 0, 0};
		logic signed [COORD_W-1:0] box_hi [3] = '{0, 0, 0};
		mesh_result_t awaited [$];
		int errors = 0;

		function int pending();
			return awaited.size();
		endfunction

		// Works out the result of one accepted request and queues it.
		function void note_request(logic cmd, logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
				logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b, logic [CORNER_W-1:0] c);
			mesh_result_t r;
			logic signed [COORD_W-1:0] pt [3];
			longint d1 [3];
			longint d2 [3];
			r = '0;
			if (cmd == CMD_VERTEX) begin
				pt[0] = x;
				pt[1] = y;
				pt[2] = z;
				if (n_vertices >= VERTEX_DEPTH) begin
					r.status = STATUS_FULL;
				end else begin
					for (int i = 0; i < 3; i++) begin
						coords_held[n_vertices][i] = pt[i];
						if (!box_started || pt[i] < box_lo[i])
							box_lo[i] = pt[i];
						if (!box_started || pt[i] > box_hi[i])
							box_hi[i] = pt[i];
					end
					box_started = 1'b1;
					r.status = STATUS_OK;
					r.entry_index = INDEX_W'(n_vertices);
					n_vertices++;
				end
				r.lo_x = box_lo[0];
				r.lo_y = box_lo[1];
				r.lo_z = box_lo[2];
				r.extent_x = box_hi[0] - box_lo[0];
				r.extent_y = box_hi[1] - box_lo[1];
				r.extent_z = box_hi[2] - box_lo[2];
			end else if (n_faces >= FACE_LIMIT) begin
				r.status = STATUS_FULL;
			end else if (a >= n_vertices || b >= n_vertices || c >= n_vertices) begin
				r.status = STATUS_UNWRITTEN;
			end else begin
				for (int i = 0; i < 3; i++) begin
					d1[i] = longint'(coords_held[a][i]) - longint'(coords_held[b][i]);
					d2[i] = longint'(coords_held[b][i]) - longint'(coords_held[c][i]);
				end
				r.status = STATUS_OK;
				r.entry_index = INDEX_W'(n_faces);
				r.normal_x = NORM_W'(d1[1] * d2[2] - d1[2] * d2[1]);
				r.normal_y = NORM_W'(d1[2] * d2[0] - d1[0] * d2[2]);
				r.normal_z = NORM_W'(d1[0] * d2[1] - d1[1] * d2[0]);
				n_faces++;
			end
			awaited.push_back(r);
		endfunction

		function void spread(mesh_result_t r, output logic signed [63:0] f [11]);
			f[0]  = {1'b0, r.status};
			f[1]  = {1'b0, r.entry_index};
			f[2]  = $signed(r.lo_x);
			f[3]  = $signed(r.lo_y);
			f[4]  = $signed(r.lo_z);
			f[5]  = {1'b0, r.extent_x};
			f[6]  = {1'b0, r.extent_y};
			f[7]  = {1'b0, r.extent_z};
			f[8]  = $signed(r.normal_x);
			f[9]  = $signed(r.normal_y);
			f[10] = $signed(r.normal_z);
		endfunction

		// Compares one accepted result with the oldest one still awaited.
		function void check_result(mesh_result_t got);
			mesh_result_t want;
			logic signed [63:0] want_f [11];
			logic signed [63:0] got_f [11];
			string label [11];
			bit bad;
			label = '{"status", "entry_index", "lo_x", "lo_y", "lo_z", "extent_x",
				"extent_y", "extent_z", "normal_x", "normal_y", "normal_z"};
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: status %0d, entry_index %0d",
						got.status, got.entry_index);
				return;
			end
			want = awaited.pop_front();
			spread(want, want_f);
			spread(got, got_f);
			bad = 1'b0;
			for (int i = 0; i < 11; i++) begin
				if (got_f[i] !== want_f[i]) begin
					if (!bad)
						errors++;
					bad = 1'b1;
					if (errors <= 10)
						$display("result mismatch on %s: expected %0d, got %0d",
							label[i], want_f[i], got_f[i]);
				end
			end
		endfunction

	endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for mesh_vertex_bbox_face_normal.
// Depends on mvbbox_pkg and on the scoreboard class in mvbbox_tb_pkg.

module tb_top;

	import mvbbox_pkg::*;
	import mvbbox_tb_pkg::*;

	// Longest wait either side draws before a request or a result.
	localparam int IDLE_MAX = 10;
	// A good face passes through the read, multiply and hand-over states in
	// the block, and both sides idle no longer than IDLE_MAX before each
	// handshake, so this limit leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last result for any stray extra output.
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_REQUESTS = 1740;

	logic clk;
	logic arst_n;

	logic                       in_valid;
	logic                       in_stall;
	logic                       command;
	logic signed [COORD_W-1:0]  coord_x;
	logic signed [COORD_W-1:0]  coord_y;
	logic signed [COORD_W-1:0]  coord_z;
	logic        [CORNER_W-1:0] corner_a;
	logic        [CORNER_W-1:0] corner_b;
	logic        [CORNER_W-1:0] corner_c;

	logic                       out_valid;
	logic                       out_stall;
	logic        [1:0]          status;
	logic        [INDEX_W-1:0]  entry_index;
	logic signed [COORD_W-1:0]  lo_x;
	logic signed [COORD_W-1:0]  lo_y;
	logic signed [COORD_W-1:0]  lo_z;
	logic        [COORD_W-1:0]  extent_x;
	logic        [COORD_W-1:0]  extent_y;
	logic        [COORD_W-1:0]  extent_z;
	logic signed [NORM_W-1:0]   normal_x;
	logic signed [NORM_W-1:0]   normal_y;
	logic signed [NORM_W-1:0]   normal_z;

	mesh_scoreboard sb = new();

	// Each side keeps its own count of remaining handshakes in a stretch
	// without idling.
	int send_burst = 0;
	int recv_burst = 0;

	mesh_vertex_bbox_face_normal u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.corner_a    (corner_a),
		.corner_b    (corner_b),
		.corner_c    (corner_c),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.entry_index (entry_index),
		.lo_x        (lo_x),
		.lo_y        (lo_y),
		.lo_z        (lo_z),
		.extent_x    (extent_x),
		.extent_y    (extent_y),
		.extent_z    (extent_z),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Draws the number of idle cycles before the next handshake. Now and then
	// a stretch of back-to-back handshakes starts, so that the block also
	// sees traffic with no gaps at all.
	function automatic int draw_wait(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, IDLE_MAX);
	endfunction

	// Coordinates lean towards the extremes of Q8.8 so that the box edges
	// and the extent wrap are hit often.
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// A good corner names a vertex already written. A bad one is either the
	// first unwritten slot, which is the boundary of the check, or anything.
	function automatic logic [CORNER_W-1:0] pick_corner(input bit good);
		if (good && sb.n_vertices > 0)
			return CORNER_W'($urandom_range(0, sb.n_vertices - 1));
		if ($urandom_range(0, 1) == 0)
			return CORNER_W'(sb.n_vertices);
		return CORNER_W'($urandom_range(0, VERTEX_DEPTH - 1));
	endfunction

	// Presents one request after a random gap and holds it until the block
	// takes it. The payload is only changed once the request has gone.
	task automatic send_request(input logic cmd, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
			input logic [CORNER_W-1:0] a, input logic [CORNER_W-1:0] b,
			input logic [CORNER_W-1:0] c);
		int gap;
		gap = draw_wait(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		coord_x  <= x;
		coord_y  <= y;
		coord_z  <= z;
		corner_a <= a;
		corner_b <= b;
		corner_c <= c;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_request(cmd, x, y, z, a, b, c);
	endtask

	// Mostly well-formed requests: vertices with random coordinates and
	// faces whose corners are all written. About one face in seven has one
	// corner redrawn as a bad one, which need not name an unwritten vertex.
	task automatic random_request(input int vertex_pct);
		logic [COORD_W-1:0] x, y, z;
		logic [CORNER_W-1:0] a, b, c;
		x = pick_coord();
		y = pick_coord();
		z = pick_coord();
		if ($urandom_range(0, 99) < vertex_pct) begin
			send_request(CMD_VERTEX, x, y, z, CORNER_W'($urandom),
				CORNER_W'($urandom), CORNER_W'($urandom));
		end else begin
			a = pick_corner(1'b1);
			b = pick_corner(1'b1);
			c = pick_corner(1'b1);
			if ($urandom_range(0, 99) < 15) begin
				case ($urandom_range(0, 2))
					0: a = pick_corner(1'b0);
					1: b = pick_corner(1'b0);
					default: c = pick_corner(1'b0);
				endcase
			end
			send_request(CMD_FACE, x, y, z, a, b, c);
		end
	endtask

	// Holds the sender back until every awaited result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Stimulus. The directed part comes first: a face before any vertex, a
	// first vertex that sets the whole box, vertices at the coordinate
	// extremes so the extents wrap to full scale, faces with large and with
	// degenerate normals, and faces naming unwritten corners in each
	// position. The random part then fills the vertex store past full, so
	// that later vertices are refused while faces keep coming.
	initial begin
		int n;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		command  <= CMD_VERTEX;
		coord_x  <= '0;
		coord_y  <= '0;
		coord_z  <= '0;
		corner_a <= '0;
		corner_b <= '0;
		corner_c <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0);
		send_request(CMD_VERTEX, 16'h8000, 16'h7FFF, 16'h0000, 10'h3FF, 10'h3FF, 10'h3FF);
		send_request(CMD_VERTEX, 16'h7FFF, 16'h8000, 16'hFFFF, 10'd0, 10'd0, 10'd0);
		send_request(CMD_VERTEX, 16'h0000, 16'h0000, 16'h7FFF, 10'd0, 10'd0, 10'd0);
		send_request(CMD_VERTEX, 16'h0001, 16'hFFFF, 16'h8000, 10'd0, 10'd0, 10'd0);
		send_request(CMD_VERTEX, 16'h7FFF, 16'h7FFF, 16'h8000, 10'd0, 10'd0, 10'd0);
		send_request(CMD_VERTEX, 16'h8000, 16'h8000, 16'h7FFF, 10'd0, 10'd0, 10'd0);
		send_request(CMD_FACE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd0, 10'd1, 10'd2);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd1, 10'd2, 10'd3);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd3, 10'd2, 10'd1);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd4, 10'd5, 10'd0);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd5, 10'd4, 10'd1);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd1, 10'd0);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd2, 10'd2, 10'd2);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd1, 10'd0, 10'd5);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd6, 10'd0, 10'd0);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd6, 10'd0);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd6);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'h3FF, 10'h3FF, 10'h3FF);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd1, 10'd512);
		send_request(CMD_VERTEX, 16'h5555, 16'hAAAA, 16'h00FF, 10'd0, 10'd0, 10'd0);
		send_request(CMD_FACE, 16'h0000, 16'h0000, 16'h0000, 10'd6, 10'd0, 10'd1);

		// Let everything drain once before the random traffic starts.
		wait_drained();

		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			random_request(62);
			if (n == RANDOM_REQUESTS / 2)
				wait_drained();
		end
		while (sb.n_vertices < VERTEX_DEPTH)
			random_request(90);

		// The store is full now, so the odd vertex is refused between faces.
		repeat (30)
			random_request(30);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("mesh_vertex_bbox_face_normal regression: pass");
		else
			$display("mesh_vertex_bbox_face_normal regression: fail");
		$finish;
	end

	// Receiver: stalls for a random number of cycles before each result,
	// then takes it and hands it to the scoreboard.
	initial begin
		int hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(recv_burst);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1)
				@(posedge clk);
			sb.check_result('{status_t'(status), entry_index, lo_x, lo_y, lo_z,
				extent_x, extent_y, extent_z, normal_x, normal_y, normal_z});
		end
	end

	// Watchdog: any handshake on either channel counts as progress.
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("mesh_vertex_bbox_face_normal regression: fail");
		$finish;
	end

endmodule
